[rtl/dts_pkg.sv]
// Shared request codes, status codes and sequencer states of the tag stack.
`default_nettype none
package dts_pkg;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_POP    = 2'd2;

  localparam logic [1:0] INS_NONE  = 2'd0;
  localparam logic [1:0] INS_ADDED = 2'd1;
  localparam logic [1:0] INS_DUP   = 2'd2;
  localparam logic [1:0] INS_FULL  = 2'd3;

  localparam int unsigned FIELD_TAG_BITS   = 64;
  localparam int unsigned FIELD_COUNT_BITS = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP_WAIT,
    ST_DONE
  } dts_state_e;

endpackage
`default_nettype wire

[rtl/dts_tag_ram.sv]
// Single-port-write, single-port-read tag memory with registered read data.
`default_nettype none
module dts_tag_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

[rtl/dedup_tag_stack.sv]
// Top level of the duplicate-free tag stack with a one-compare-per-cycle scan.
//
// Usage: requests enter on the s_axis channel, one item each, with the request
// kind in tuser (clear, insert, pop) and the tag in tdata. Each request gives
// exactly one result item on the m_axis channel carrying the popped tag, the
// pop-valid flag, the insert status and the entry count after the request.
// Sequence: clear, unknown and empty-store pop requests go from accept straight
// to the done state; a pop of a stored tag passes through a wait state for the
// memory read; an insert scans the stored tags until a match or the end (a full
// store skips the scan). The insert scan reads one stored tag per cycle from the
// tag memory and compares it in a single shared comparator; the memory read
// port sets that figure. s_axis_tready_o is high only while the sequencer is
// idle, so one request is worked on at a time.
// The result sits in an output register; the next request is accepted while
// it waits, and its own result is held back until the receiver takes the
// previous one. A stall on m_axis therefore stalls the sequencer at its end.
// Reset empties the store and clears the output; the memory itself is not
// cleared, since only entries below the count are ever read.
`default_nettype none
module dedup_tag_stack #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned TAG_BITS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // tag_value[63:0]
  input  wire logic [7:0]  s_axis_tuser_i,   // req_type[1:0], zeros[7:2]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [71:0] m_axis_tdata_o,   // tag_out[63:0], entry_count[70:64], zero[71]
  output logic      [7:0]  m_axis_tuser_o    // tag_out_valid[0], insert_status[2:1], zeros[7:3]
);
  import dts_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

  dts_state_e state_q, state_d;

  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic                cmp_valid_q, cmp_valid_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic [TAG_BITS-1:0] res_tag_q, res_tag_d;
  logic                res_tvalid_q, res_tvalid_d;
  logic [1:0]          res_status_q, res_status_d;

  logic                out_valid_q, out_valid_d;
  logic [TAG_BITS-1:0] out_tag_q, out_tag_d;
  logic                out_tvalid_q, out_tvalid_d;
  logic [1:0]          out_status_q, out_status_d;
  logic [FIELD_COUNT_BITS-1:0] out_count_q, out_count_d;

  logic                in_acc;
  logic [1:0]          req;
  logic                out_free;
  logic                full;
  logic                issue;
  logic                match;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [TAG_BITS-1:0] ram_rdata;

  logic [CNT_W-1:0]    count_dec;
  logic [CNT_W+FIELD_COUNT_BITS-1:0] count_wide;
  logic [TAG_BITS+FIELD_TAG_BITS-1:0] tag_wide;

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign req       = s_axis_tuser_i[1:0];
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign full      = (count_q >= MAX_CNT);
  assign issue     = (state_q == ST_SCAN) && (idx_q < count_q);
  assign match     = cmp_valid_q && (ram_rdata == tag_q);
  assign count_dec = count_q - CNT_W'(1);
  assign count_wide = {{FIELD_COUNT_BITS{1'b0}}, count_q};
  assign tag_wide   = {{FIELD_TAG_BITS{1'b0}}, res_tag_q};

  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (req == REQ_INSERT) begin
            state_d = full ? ST_DONE : ST_SCAN;
          end else if (req == REQ_POP && count_q != '0) begin
            state_d = ST_POP_WAIT;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (match || (!issue && !cmp_valid_q)) begin
          state_d = ST_DONE;
        end
      end
      ST_POP_WAIT: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    count_d      = count_q;
    idx_d        = idx_q;
    cmp_valid_d  = 1'b0;
    tag_d        = tag_q;
    res_tag_d    = res_tag_q;
    res_tvalid_d = res_tvalid_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_tag_d    = out_tag_q;
    out_tvalid_d = out_tvalid_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    ram_we       = 1'b0;
    ram_waddr    = count_q[ADDR_W-1:0];
    ram_re       = 1'b0;
    ram_raddr    = idx_q[ADDR_W-1:0];
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          tag_d        = s_axis_tdata_i[TAG_BITS-1:0];
          idx_d        = '0;
          res_tag_d    = '0;
          res_tvalid_d = 1'b0;
          res_status_d = INS_NONE;
          if (req == REQ_CLEAR) begin
            count_d = '0;
          end else if (req == REQ_INSERT && full) begin
            res_status_d = INS_FULL;
          end else if (req == REQ_POP && count_q != '0) begin
            count_d   = count_dec;
            ram_re    = 1'b1;
            ram_raddr = count_dec[ADDR_W-1:0];
          end
        end
      end
      ST_SCAN: begin
        ram_re      = issue;
        cmp_valid_d = issue;
        if (issue) begin
          idx_d = idx_q + CNT_W'(1);
        end
        if (match) begin
          res_status_d = INS_DUP;
          cmp_valid_d  = 1'b0;
        end else if (!issue && !cmp_valid_q) begin
          ram_we       = 1'b1;
          count_d      = count_q + CNT_W'(1);
          res_status_d = INS_ADDED;
        end
      end
      ST_POP_WAIT: begin
        res_tag_d    = ram_rdata;
        res_tvalid_d = 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_tag_d    = res_tag_q;
          out_tvalid_d = res_tvalid_q;
          out_status_d = res_status_q;
          out_count_d  = count_wide[FIELD_COUNT_BITS-1:0];
        end
      end
      default: begin
        cmp_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      cmp_valid_q <= cmp_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q        <= tag_d;
    res_tag_q    <= res_tag_d;
    res_tvalid_q <= res_tvalid_d;
    res_status_q <= res_status_d;
    out_tag_q    <= out_tag_d;
    out_tvalid_q <= out_tvalid_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  dts_tag_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (TAG_BITS),
    .ADDR_W(ADDR_W)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(tag_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  logic [TAG_BITS+FIELD_TAG_BITS-1:0] out_tag_wide;
  assign out_tag_wide = {{FIELD_TAG_BITS{1'b0}}, out_tag_q};

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_count_q, out_tag_wide[FIELD_TAG_BITS-1:0]};
  assign m_axis_tuser_o  = {5'b0, out_status_q, out_tvalid_q};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_CNT)
    else $error("entry count above capacity");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && req == REQ_CLEAR) |=> (count_q == '0))
    else $error("clear did not empty the store");

  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (!full && !cmp_valid_q))
    else $error("tag written into a full store or during a compare");

  a_write_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("append did not advance the count");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP_WAIT) |-> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("pop did not lower the count");
`endif

  logic unused_tag_wide;
  assign unused_tag_wide = ^{tag_wide, s_axis_tuser_i[7:2],
                             out_tag_wide[TAG_BITS+FIELD_TAG_BITS-1:FIELD_TAG_BITS],
                             count_wide[CNT_W+FIELD_COUNT_BITS-1:FIELD_COUNT_BITS]};

endmodule
`default_nettype wire
